// File: rtl/mm4r_pkg.sv
package mm4r_pkg;

   localparam int unsigned MATRIX_DIM_DEFAULT = 4;
   localparam int unsigned WORD_WIDTH_DEFAULT = 32;

   // the row transaction carries four a columns and the result four m columns
   localparam int unsigned LANES       = 4;
   localparam int unsigned FIELD_WIDTH = 32;
   localparam int unsigned TAG_WIDTH   = 2;
   localparam int unsigned INDEX_WIDTH = 4;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_ROW  = 1'b1
   } op_type;

   typedef struct packed {
      logic                 valid;
      logic [TAG_WIDTH-1:0] row_tag;
   } stage_ctl_type;

endpackage

// File: rtl/mm4r_bstore.sv
module mm4r_bstore #(
   parameter int unsigned MATRIX_DIM = 4,
   parameter int unsigned WORD_WIDTH = 32
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     wr_en,
   input  logic [mm4r_pkg::INDEX_WIDTH-1:0]         wr_index,
   input  logic signed [WORD_WIDTH-1:0]             wr_value,
   output logic signed [WORD_WIDTH-1:0]             b_out [mm4r_pkg::LANES][mm4r_pkg::LANES]
);
   import mm4r_pkg::*;

   localparam int unsigned INDEX_SPAN = 1 << INDEX_WIDTH;

   // only the entries that a four column row can reach and a load index can name are kept
   for (genvar k = 0; k < LANES; k++) begin : g_row
      for (genvar j = 0; j < LANES; j++) begin : g_col
         if (k < MATRIX_DIM && j < MATRIX_DIM && (k * MATRIX_DIM + j) < INDEX_SPAN) begin : g_entry
            localparam logic [INDEX_WIDTH-1:0] ENTRY = INDEX_WIDTH'(k * MATRIX_DIM + j);
            logic signed [WORD_WIDTH-1:0] b_ff;
            logic signed [WORD_WIDTH-1:0] b_in;

            always_comb begin
               b_in = b_ff;
               if (wr_en && wr_index == ENTRY) begin
                  b_in = wr_value;
               end
            end

            always_ff @(posedge clock) begin
               if (reset) begin
                  b_ff <= '0;
               end else begin
                  b_ff <= b_in;
               end
            end

            assign b_out[k][j] = b_ff;
         end else begin : g_none
            assign b_out[k][j] = '0;
         end
      end
   end

endmodule

// File: rtl/mm4r_mult.sv
module mm4r_mult #(
   parameter int unsigned MATRIX_DIM = 4,
   parameter int unsigned WORD_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mm4r_pkg::stage_ctl_type             in_ctl,
   output logic                                in_ready,
   input  logic signed [WORD_WIDTH-1:0]        a_in [mm4r_pkg::LANES],
   input  logic signed [WORD_WIDTH-1:0]        b_in [mm4r_pkg::LANES][mm4r_pkg::LANES],
   output mm4r_pkg::stage_ctl_type             out_ctl,
   input  logic                                out_ready,
   output logic signed [2*WORD_WIDTH-1:0]      prod [mm4r_pkg::LANES][mm4r_pkg::LANES]
);
   import mm4r_pkg::*;

   localparam int unsigned PROD_WIDTH = 2 * WORD_WIDTH;

   stage_ctl_type ctl_ff;
   logic signed [PROD_WIDTH-1:0] prod_ff [LANES][LANES];
   logic signed [PROD_WIDTH-1:0] prod_in [LANES][LANES];

   assign in_ready = !ctl_ff.valid || out_ready;

   // prod[j][k] is a_k times B[k][j]; lanes outside the matrix stay zero
   for (genvar j = 0; j < LANES; j++) begin : g_col
      for (genvar k = 0; k < LANES; k++) begin : g_term
         if (j < MATRIX_DIM && k < MATRIX_DIM) begin : g_mul
            assign prod_in[j][k] = a_in[k] * b_in[k][j];
         end else begin : g_zero
            assign prod_in[j][k] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (in_ready) begin
         ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_ctl.valid) begin
         prod_ff <= prod_in;
      end
   end

   assign out_ctl = ctl_ff;
   assign prod    = prod_ff;

endmodule

// File: rtl/mm4r_sum.sv
module mm4r_sum #(
   parameter int unsigned WORD_WIDTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  mm4r_pkg::stage_ctl_type                in_ctl,
   output logic                                   in_ready,
   input  logic signed [2*WORD_WIDTH-1:0]         prod [mm4r_pkg::LANES][mm4r_pkg::LANES],
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic [mm4r_pkg::TAG_WIDTH-1:0]         out_tag,
   output logic signed [mm4r_pkg::FIELD_WIDTH-1:0] out_m [mm4r_pkg::LANES],
   output logic                                   out_sat
);
   import mm4r_pkg::*;

   localparam int unsigned PROD_WIDTH = 2 * WORD_WIDTH;
   localparam int unsigned SUM_WIDTH  = PROD_WIDTH + 2;
   localparam int unsigned FRAC_BITS  = WORD_WIDTH / 2;
   localparam int unsigned HIGH_WIDTH = SUM_WIDTH - (WORD_WIDTH - 1 + FRAC_BITS);

   localparam logic signed [WORD_WIDTH-1:0] WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
   localparam logic signed [WORD_WIDTH-1:0] WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

   logic                          valid_ff;
   logic [TAG_WIDTH-1:0]          tag_ff;
   logic signed [FIELD_WIDTH-1:0] m_ff [LANES];
   logic signed [FIELD_WIDTH-1:0] m_in [LANES];
   logic                          sat_ff;
   logic                          sat_in;
   logic [LANES-1:0]              col_sat;

   assign in_ready = !valid_ff || out_ready;

   for (genvar j = 0; j < LANES; j++) begin : g_col
      logic signed [SUM_WIDTH-1:0]  acc;
      logic        [HIGH_WIDTH-1:0] high;
      logic signed [WORD_WIDTH-1:0] word;

      always_comb begin
         acc = '0;
         for (int k = 0; k < LANES; k++) begin
            acc = acc + SUM_WIDTH'(prod[j][k]);
         end
      end

      // floor shift of the exact sum, then clip when the upper bits are not all sign
      assign high = acc[SUM_WIDTH-1:WORD_WIDTH-1+FRAC_BITS];

      always_comb begin
         col_sat[j] = !((&high) || !(|high));
         if (!col_sat[j]) begin
            word = acc[WORD_WIDTH-1+FRAC_BITS:FRAC_BITS];
         end else if (acc[SUM_WIDTH-1]) begin
            word = WORD_MIN;
         end else begin
            word = WORD_MAX;
         end
         m_in[j] = FIELD_WIDTH'(word);
      end
   end

   assign sat_in = |col_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_ctl.valid) begin
         tag_ff <= in_ctl.row_tag;
         m_ff   <= m_in;
         sat_ff <= sat_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_tag   = tag_ff;
   assign out_m     = m_ff;
   assign out_sat   = sat_ff;

endmodule

// File: rtl/matrix4x4_multiply_rows_top.sv
// row-streamed 4x4 matrix product in signed fixed point, m = a times b
// req channel (req_valid / req_ready) carries two kinds of transaction:
//   req_op load: writes b[req_b_index] = req_b_value, gives no result
//   req_op row:  one row of a in req_a_col0..3 plus req_row_tag
// rsp channel (rsp_valid / rsp_ready) gives one transaction per row:
//   rsp_m_col0..3 = sum over k of a_k * b[k][j], shifted down by the
//   fraction bits (floor) and clipped to the word range, rsp_saturated set
//   when any column clipped, rsp_out_row_tag echoing the row tag
// pipeline: input register, product register (16 multipliers), result
// register; an accepted row passes through all three before it shows on rsp
// throughput is one transaction per cycle while rsp_ready stays high, set by
// the single pass through the multiplier stage; loads apply in order with the rows around them
// reset clears b to zero and empties the pipeline
// when rsp_ready is low the stages fill up behind the waiting result and
// req_ready drops once all three hold a row; nothing is dropped
module matrix4x4_multiply_rows_top #(
   parameter int unsigned MATRIX_DIM = mm4r_pkg::MATRIX_DIM_DEFAULT,
   parameter int unsigned WORD_WIDTH = mm4r_pkg::WORD_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_op,
   input  logic [mm4r_pkg::INDEX_WIDTH-1:0]       req_b_index,
   input  logic signed [mm4r_pkg::FIELD_WIDTH-1:0] req_b_value,
   input  logic [mm4r_pkg::TAG_WIDTH-1:0]         req_row_tag,
   input  logic signed [mm4r_pkg::FIELD_WIDTH-1:0] req_a_col0,
   input  logic signed [mm4r_pkg::FIELD_WIDTH-1:0] req_a_col1,
   input  logic signed [mm4r_pkg::FIELD_WIDTH-1:0] req_a_col2,
   input  logic signed [mm4r_pkg::FIELD_WIDTH-1:0] req_a_col3,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [mm4r_pkg::TAG_WIDTH-1:0]         rsp_out_row_tag,
   output logic signed [mm4r_pkg::FIELD_WIDTH-1:0] rsp_m_col0,
   output logic signed [mm4r_pkg::FIELD_WIDTH-1:0] rsp_m_col1,
   output logic signed [mm4r_pkg::FIELD_WIDTH-1:0] rsp_m_col2,
   output logic signed [mm4r_pkg::FIELD_WIDTH-1:0] rsp_m_col3,
   output logic                                   rsp_saturated
);
   import mm4r_pkg::*;

   localparam int unsigned PROD_WIDTH = 2 * WORD_WIDTH;

   logic                          s1_valid_ff;
   op_type                        s1_op_ff;
   logic [TAG_WIDTH-1:0]          s1_tag_ff;
   logic [INDEX_WIDTH-1:0]        s1_index_ff;
   logic signed [WORD_WIDTH-1:0]  s1_value_ff;
   logic signed [WORD_WIDTH-1:0]  s1_a_ff [LANES];
   logic signed [WORD_WIDTH-1:0]  a_in [LANES];
   logic                          s1_ready;
   logic                          req_fire;

   logic signed [WORD_WIDTH-1:0]  b_cur [LANES][LANES];
   stage_ctl_type                 mult_in_ctl;
   logic                          mult_in_ready;
   stage_ctl_type                 sum_in_ctl;
   logic                          sum_in_ready;
   logic signed [PROD_WIDTH-1:0]  prod [LANES][LANES];
   logic signed [FIELD_WIDTH-1:0] m_out [LANES];

   assign a_in[0] = req_a_col0[WORD_WIDTH-1:0];
   assign a_in[1] = req_a_col1[WORD_WIDTH-1:0];
   assign a_in[2] = req_a_col2[WORD_WIDTH-1:0];
   assign a_in[3] = req_a_col3[WORD_WIDTH-1:0];

   // a load leaves the input register at once, a row waits for the multiplier stage
   assign s1_ready  = !s1_valid_ff || s1_op_ff == OP_LOAD || mult_in_ready;
   assign req_ready = s1_ready;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff    <= op_type'(req_op);
         s1_tag_ff   <= req_row_tag;
         s1_index_ff <= req_b_index;
         s1_value_ff <= req_b_value[WORD_WIDTH-1:0];
         s1_a_ff     <= a_in;
      end
   end

   mm4r_bstore #(
      .MATRIX_DIM (MATRIX_DIM),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_bstore (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (s1_valid_ff && s1_op_ff == OP_LOAD),
      .wr_index (s1_index_ff),
      .wr_value (s1_value_ff),
      .b_out    (b_cur)
   );

   assign mult_in_ctl = '{valid: s1_valid_ff && s1_op_ff == OP_ROW, row_tag: s1_tag_ff};

   mm4r_mult #(
      .MATRIX_DIM (MATRIX_DIM),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (mult_in_ctl),
      .in_ready  (mult_in_ready),
      .a_in      (s1_a_ff),
      .b_in      (b_cur),
      .out_ctl   (sum_in_ctl),
      .out_ready (sum_in_ready),
      .prod      (prod)
   );

   mm4r_sum #(
      .WORD_WIDTH (WORD_WIDTH)
   ) u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (sum_in_ctl),
      .in_ready  (sum_in_ready),
      .prod      (prod),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_tag   (rsp_out_row_tag),
      .out_m     (m_out),
      .out_sat   (rsp_saturated)
   );

   assign rsp_m_col0 = m_out[0];
   assign rsp_m_col1 = m_out[1];
   assign rsp_m_col2 = m_out[2];
   assign rsp_m_col3 = m_out[3];

endmodule

// File: rtl/mm4r_checker.sv
module mm4r_checker #(
   parameter int unsigned MATRIX_DIM = mm4r_pkg::MATRIX_DIM_DEFAULT,
   parameter int unsigned WORD_WIDTH = mm4r_pkg::WORD_WIDTH_DEFAULT
) (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    rsp_valid,
   input logic                                    rsp_ready,
   input logic [mm4r_pkg::TAG_WIDTH-1:0]          rsp_out_row_tag,
   input logic signed [mm4r_pkg::FIELD_WIDTH-1:0] rsp_m_col0,
   input logic signed [mm4r_pkg::FIELD_WIDTH-1:0] rsp_m_col1,
   input logic signed [mm4r_pkg::FIELD_WIDTH-1:0] rsp_m_col2,
   input logic signed [mm4r_pkg::FIELD_WIDTH-1:0] rsp_m_col3,
   input logic                                    rsp_saturated
);
   import mm4r_pkg::*;

   localparam logic signed [FIELD_WIDTH-1:0] SAT_MAX =
      FIELD_WIDTH'($signed({1'b0, {(WORD_WIDTH-1){1'b1}}}));
   localparam logic signed [FIELD_WIDTH-1:0] SAT_MIN =
      FIELD_WIDTH'($signed({1'b1, {(WORD_WIDTH-1){1'b0}}}));

   logic signed [FIELD_WIDTH-1:0] m_col [LANES];
   logic [LANES-1:0]              at_limit;
   logic [LANES-1:0]              ext_ok;
   logic [LANES-1:0]              unused_zero;

   assign m_col[0] = rsp_m_col0;
   assign m_col[1] = rsp_m_col1;
   assign m_col[2] = rsp_m_col2;
   assign m_col[3] = rsp_m_col3;

   for (genvar j = 0; j < LANES; j++) begin : g_col
      assign at_limit[j]    = m_col[j] == SAT_MAX || m_col[j] == SAT_MIN;
      assign ext_ok[j]      = m_col[j] == FIELD_WIDTH'($signed(m_col[j][WORD_WIDTH-1:0]));
      assign unused_zero[j] = j < MATRIX_DIM || m_col[j] == '0;
   end

   // a stalled result holds its tag, values and flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_row_tag)
         && $stable(rsp_m_col0) && $stable(rsp_m_col1) && $stable(rsp_m_col2)
         && $stable(rsp_m_col3) && $stable(rsp_saturated))
      else $error("stalled result changed");

   // a clipped row has at least one column at a limit of the word range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> |at_limit)
      else $error("saturated flag without a clipped column");

   // every column is a sign-extended word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> &ext_ok)
      else $error("result column not sign-extended from the word width");

   // columns beyond the matrix size read zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> &unused_zero)
      else $error("column beyond the matrix size not zero");

   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind matrix4x4_multiply_rows_top mm4r_checker #(
   .MATRIX_DIM (MATRIX_DIM),
   .WORD_WIDTH (WORD_WIDTH)
) u_mm4r_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_row_tag (rsp_out_row_tag),
   .rsp_m_col0      (rsp_m_col0),
   .rsp_m_col1      (rsp_m_col1),
   .rsp_m_col2      (rsp_m_col2),
   .rsp_m_col3      (rsp_m_col3),
   .rsp_saturated   (rsp_saturated)
);

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import mm4r_pkg::*;

   typedef struct {
      logic [TAG_WIDTH-1:0]          tag;
      logic signed [FIELD_WIDTH-1:0] m [LANES];
      logic                          sat;
   } row_result_type;

   // holds the b store and the rows the block still owes us
   class row_product_board;
      logic signed [FIELD_WIDTH-1:0] b_store [LANES*LANES];
      row_result_type                expected_rows [$];
      int                            mismatches;
      int                            rows_checked;
      int                            sat_rows;

      function new();
         foreach (b_store[i]) b_store[i] = '0;
         mismatches   = 0;
         rows_checked = 0;
         sat_rows     = 0;
      endfunction

      function int pending();
         return expected_rows.size();
      endfunction

      // exact sum of products, floor shift by the fraction bits, then clip
      function row_result_type product_row(logic [TAG_WIDTH-1:0] tag,
                                           logic signed [FIELD_WIDTH-1:0] a [LANES]);
         row_result_type     r;
         logic signed [66:0] acc;
         logic signed [66:0] pa;
         logic signed [66:0] pb;
         logic signed [66:0] q;
         r.tag = tag;
         r.sat = 1'b0;
         for (int j = 0; j < LANES; j++) begin
            acc = '0;
            for (int k = 0; k < LANES; k++) begin
               pa  = a[k];
               pb  = b_store[k*LANES + j];
               acc = acc + pa * pb;
            end
            q = acc >>> (FIELD_WIDTH / 2);
            if (q > 67'sd2147483647) begin
               r.m[j] = 32'sh7fff_ffff;
               r.sat  = 1'b1;
            end else if (q < -67'sd2147483648) begin
               r.m[j] = 32'sh8000_0000;
               r.sat  = 1'b1;
            end else begin
               r.m[j] = q[FIELD_WIDTH-1:0];
            end
         end
         return r;
      endfunction

      function void note_request(op_type op, logic [INDEX_WIDTH-1:0] idx,
                                 logic signed [FIELD_WIDTH-1:0] bval,
                                 logic [TAG_WIDTH-1:0] tag,
                                 logic signed [FIELD_WIDTH-1:0] a0,
                                 logic signed [FIELD_WIDTH-1:0] a1,
                                 logic signed [FIELD_WIDTH-1:0] a2,
                                 logic signed [FIELD_WIDTH-1:0] a3);
         logic signed [FIELD_WIDTH-1:0] a [LANES];
         if (op == OP_LOAD) begin
            b_store[idx] = bval;
         end else begin
            a[0] = a0;
            a[1] = a1;
            a[2] = a2;
            a[3] = a3;
            expected_rows.push_back(product_row(tag, a));
         end
      endfunction

      function void compare_field(string what, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: %s expected %h got %h", $time, what, want, got);
         end
      endfunction

      function void check_row(logic [TAG_WIDTH-1:0] tag,
                              logic signed [FIELD_WIDTH-1:0] m0,
                              logic signed [FIELD_WIDTH-1:0] m1,
                              logic signed [FIELD_WIDTH-1:0] m2,
                              logic signed [FIELD_WIDTH-1:0] m3,
                              logic sat);
         row_result_type want;
         if (expected_rows.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result row with tag %0d arrived with none expected",
                        $time, tag);
            return;
         end
         want = expected_rows.pop_front();
         rows_checked++;
         if (want.sat) sat_rows++;
         compare_field("row tag", 32'(want.tag), 32'(tag));
         compare_field("m col0", want.m[0], m0);
         compare_field("m col1", want.m[1], m1);
         compare_field("m col2", want.m[2], m2);
         compare_field("m col3", want.m[3], m3);
         compare_field("saturated", 32'(want.sat), 32'(sat));
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   op_type                        req_op = OP_LOAD;
   logic [INDEX_WIDTH-1:0]        req_b_index = '0;
   logic signed [FIELD_WIDTH-1:0] req_b_value = '0;
   logic [TAG_WIDTH-1:0]          req_row_tag = '0;
   logic signed [FIELD_WIDTH-1:0] req_a_col0 = '0;
   logic signed [FIELD_WIDTH-1:0] req_a_col1 = '0;
   logic signed [FIELD_WIDTH-1:0] req_a_col2 = '0;
   logic signed [FIELD_WIDTH-1:0] req_a_col3 = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [TAG_WIDTH-1:0]          rsp_out_row_tag;
   logic signed [FIELD_WIDTH-1:0] rsp_m_col0;
   logic signed [FIELD_WIDTH-1:0] rsp_m_col1;
   logic signed [FIELD_WIDTH-1:0] rsp_m_col2;
   logic signed [FIELD_WIDTH-1:0] rsp_m_col3;
   logic                          rsp_saturated;

   row_product_board sb;
   int               loads_sent;
   int               rows_sent;
   int               burst_left;

   matrix4x4_multiply_rows_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_b_index     (req_b_index),
      .req_b_value     (req_b_value),
      .req_row_tag     (req_row_tag),
      .req_a_col0      (req_a_col0),
      .req_a_col1      (req_a_col1),
      .req_a_col2      (req_a_col2),
      .req_a_col3      (req_a_col3),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_row_tag (rsp_out_row_tag),
      .rsp_m_col0      (rsp_m_col0),
      .rsp_m_col1      (rsp_m_col1),
      .rsp_m_col2      (rsp_m_col2),
      .rsp_m_col3      (rsp_m_col3),
      .rsp_saturated   (rsp_saturated)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic signed [FIELD_WIDTH-1:0] rand_word();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom;
         // small magnitudes, roughly -4.0 to +4.0, so sums rarely clip
         4, 5, 6, 7: return $signed(32'($urandom_range(0, 32'h8_0000))) - 32'sh4_0000;
         8: begin
            case ($urandom_range(0, 5))
               0: return 32'sh7fff_ffff;
               1: return 32'sh8000_0000;
               2: return 32'sh0000_0000;
               3: return 32'sh0000_0001;
               4: return 32'shffff_ffff;
               default: return 32'sh0001_0000;
            endcase
         end
         default: begin
            if ($urandom_range(0, 1) == 0)
               return 32'sh1 <<< $urandom_range(0, 31);
            return -(32'sh1 <<< $urandom_range(0, 30));
         end
      endcase
   endfunction

   // called at a rising edge, returns at the edge that accepted the transaction
   task automatic send_item(op_type op, logic [INDEX_WIDTH-1:0] idx,
                            logic signed [FIELD_WIDTH-1:0] bval,
                            logic [TAG_WIDTH-1:0] tag,
                            logic signed [FIELD_WIDTH-1:0] a0,
                            logic signed [FIELD_WIDTH-1:0] a1,
                            logic signed [FIELD_WIDTH-1:0] a2,
                            logic signed [FIELD_WIDTH-1:0] a3);
      req_valid   <= 1'b1;
      req_op      <= op;
      req_b_index <= idx;
      req_b_value <= bval;
      req_row_tag <= tag;
      req_a_col0  <= a0;
      req_a_col1  <= a1;
      req_a_col2  <= a2;
      req_a_col3  <= a3;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(op, idx, bval, tag, a0, a1, a2, a3);
      if (op == OP_LOAD) loads_sent++;
      else rows_sent++;
   endtask

   task automatic idle_sender(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // bursts of random length with random gaps, some bursts back to back
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) idle_sender(gap);
      end
      burst_left--;
   endtask

   task automatic load_b(logic [INDEX_WIDTH-1:0] idx, logic signed [FIELD_WIDTH-1:0] bval);
      send_item(OP_LOAD, idx, bval, TAG_WIDTH'($urandom), rand_word(), rand_word(),
                rand_word(), rand_word());
   endtask

   task automatic send_row(logic [TAG_WIDTH-1:0] tag, logic signed [FIELD_WIDTH-1:0] a0,
                           logic signed [FIELD_WIDTH-1:0] a1,
                           logic signed [FIELD_WIDTH-1:0] a2,
                           logic signed [FIELD_WIDTH-1:0] a3);
      send_item(OP_ROW, INDEX_WIDTH'($urandom), rand_word(), tag, a0, a1, a2, a3);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_row(rsp_out_row_tag, rsp_m_col0, rsp_m_col1, rsp_m_col2, rsp_m_col3,
                      rsp_saturated);
   end

   // receiver: changes its stall pattern now and then, and holds off for a long
   // stretch twice while the sender keeps going
   initial begin
      int cyc;
      int mode;
      int hold_left;
      int holds_done;
      cyc        = 0;
      mode       = 0;
      hold_left  = 0;
      holds_done = 0;
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc % 80 == 0) mode = $urandom_range(0, 3);
         if ((holds_done == 0 && sb.rows_checked >= 60) ||
             (holds_done == 1 && sb.rows_checked >= 250)) begin
            hold_left = 200;
            holds_done++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 1) == 1);
               2: rsp_ready <= (cyc % 4 == 0);
               default: rsp_ready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   initial begin
      int order [LANES*LANES];
      int pick;
      int tmp;
      int phase;
      int count;
      sb         = new();
      loads_sent = 0;
      rows_sent  = 0;
      burst_left = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // b is zero after reset
      send_row(2'd0, 32'sh7fff_ffff, 32'sh8000_0000, 32'shffff_ffff, 32'sh0000_0001);
      // identity passes the extremes through
      load_b(4'd0, 32'sh0001_0000);
      load_b(4'd5, 32'sh0001_0000);
      load_b(4'd10, 32'sh0001_0000);
      load_b(4'd15, 32'sh0001_0000);
      send_row(2'd1, 32'sh7fff_ffff, 32'sh8000_0000, 32'shffff_ffff, 32'sh0000_0001);
      send_row(2'd2, 32'sh0, 32'sh0, 32'sh0, 32'sh0);
      // clip high and low in column 0
      load_b(4'd0, 32'sh7fff_ffff);
      load_b(4'd4, 32'sh7fff_ffff);
      send_row(2'd3, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh0, 32'sh0);
      send_row(2'd0, 32'sh8000_0000, 32'sh8000_0000, 32'sh0, 32'sh0);
      // largest exact sum: four products of the most negative words
      load_b(4'd0, 32'sh8000_0000);
      load_b(4'd4, 32'sh8000_0000);
      load_b(4'd8, 32'sh8000_0000);
      load_b(4'd12, 32'sh8000_0000);
      send_row(2'd1, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      // floor rounding of tiny products
      load_b(4'd0, 32'sh0000_0001);
      send_row(2'd2, 32'shffff_ffff, 32'sh0, 32'sh0, 32'sh0);
      send_row(2'd3, 32'sh0000_0001, 32'sh0, 32'sh0, 32'sh0);
      load_b(4'd15, 32'shffff_ffff);
      send_row(2'd0, 32'sh0, 32'sh0, 32'sh0, 32'sh8000_0000);
      wait_drained();

      count = 0;
      while (loads_sent + rows_sent < 440) begin
         phase = $urandom_range(0, 9);
         count++;
         if (count % 8 == 0) begin
            wait_drained();
         end else if (phase < 4) begin
            // full matrix in shuffled order, then its four rows
            foreach (order[i]) order[i] = i;
            for (int i = LANES*LANES - 1; i > 0; i--) begin
               pick        = $urandom_range(0, i);
               tmp         = order[i];
               order[i]    = order[pick];
               order[pick] = tmp;
            end
            foreach (order[i]) begin
               pace_sender();
               load_b(INDEX_WIDTH'(order[i]), rand_word());
            end
            for (int r = 0; r < LANES; r++) begin
               pace_sender();
               send_row(TAG_WIDTH'(r), rand_word(), rand_word(), rand_word(), rand_word());
            end
         end else if (phase < 7) begin
            // a few element updates between rows
            repeat ($urandom_range(1, 4)) begin
               pace_sender();
               load_b(INDEX_WIDTH'($urandom), rand_word());
            end
            repeat ($urandom_range(2, 6)) begin
               pace_sender();
               send_row(TAG_WIDTH'($urandom), rand_word(), rand_word(), rand_word(),
                        rand_word());
            end
         end else begin
            repeat ($urandom_range(4, 12)) begin
               pace_sender();
               send_row(TAG_WIDTH'($urandom), rand_word(), rand_word(), rand_word(),
                        rand_word());
            end
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      $display("sent %0d loads and %0d rows, checked %0d result rows (%0d clipped)",
               loads_sent, rows_sent, sb.rows_checked, sb.sat_rows);
      $display("mismatches: %0d, rows still owed: %0d", sb.mismatches, sb.pending());
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
